[rtl/prlt_pkg.sv]
// ----------------------------------------------------------------------------
// prlt_pkg
// Shared types and constants of the pending request latency tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prlt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 48;
    localparam int TMO_W  = 23;
    localparam int LIM_W  = 33;
    localparam int SUM_W  = 64;
    localparam int OUT_W  = 5;

    // Microseconds per millisecond.
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // One divider step per quotient bit.
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);

    // Item function codes.
    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_ACK    = 2'd1,
        FN_EXPIRE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_STATS,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic scan_end;
        logic append;
        logic stats;
        logic div_step;
        logic avg_load;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  scan_done;
        logic  found;
        logic  div_done;
        logic  out_free;
    } t_status;

endpackage

[rtl/prlt_ctrl.sv]
// ----------------------------------------------------------------------------
// prlt_ctrl
// Controller state machine: sequences the table scan, append, statistics
// update, average division and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlt_ctrl
    import prlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.func == FN_CLEAR) begin
                    n_state = S_OUT;
                end else if (i_status.scan_done) begin
                    o_cmd.scan_end = 1'b1;
                    priority if (i_status.func == FN_ADD) begin
                        n_state = S_APPEND;
                    end else if (i_status.func == FN_ACK && i_status.found) begin
                        n_state = S_STATS;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_OUT;
            end
            S_STATS: begin
                o_cmd.stats = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/prlt_dp.sv]
// ----------------------------------------------------------------------------
// prlt_dp
// Datapath: request table, compacting scan, statistics registers, a
// bit-serial divider for the average and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlt_dp
    import prlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [1:0]        i_func,
    input  logic [SEQ_W-1:0]  i_ack_sequence,
    input  logic [TIME_W-1:0] i_now_us,
    input  logic              i_cfg_valid,
    input  logic [TMO_W-1:0]  i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [271:0]      o_out_data
);

    // Table storage (no reset, only entries below the count are read).
    logic [SEQ_W-1:0]  r_tbl_seq  [TABLE_DEPTH];
    logic [TIME_W-1:0] r_tbl_time [TABLE_DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_wr;
    logic [SEQ_W-1:0]  r_next_seq;
    logic [TMO_W-1:0]  r_timeout;
    logic [LIM_W-1:0]  r_limit;

    // Registered item.
    t_func             r_func;
    logic [SEQ_W-1:0]  r_ack_seq;
    logic [TIME_W-1:0] r_now;

    // Per-item results.
    logic [SEQ_W-1:0]  r_assigned;
    logic              r_found;
    logic [TIME_W-1:0] r_lat;
    logic [OUT_W-1:0]  r_expired;

    // Statistics.
    logic [SEQ_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sum;
    logic [TIME_W-1:0] r_min;
    logic [TIME_W-1:0] r_max;
    logic [TIME_W-1:0] r_avg;

    // Divider.
    logic [SUM_W-1:0]  r_quo;
    logic [SEQ_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;

    logic              r_out_valid;
    logic [271:0]      r_out_data;

    // Scan: current entry and whether it is dropped.
    logic [SEQ_W-1:0]  w_ent_seq;
    logic [TIME_W-1:0] w_ent_time;
    logic [TIME_W-1:0] w_age;
    logic              w_hit;
    logic              w_drop;

    assign w_ent_seq  = r_tbl_seq[r_rd[IDX_W-1:0]];
    assign w_ent_time = r_tbl_time[r_rd[IDX_W-1:0]];
    assign w_age      = r_now - w_ent_time;
    assign w_hit      = (r_func == FN_ACK) && !r_found && (w_ent_seq == r_ack_seq);

    always_comb begin
        unique case (r_func)
            FN_ADD:    w_drop = (r_count == CNT_W'(TABLE_DEPTH)) && (r_rd == '0);
            FN_ACK:    w_drop = w_hit;
            FN_EXPIRE: w_drop = ({{(TIME_W - LIM_W){1'b0}}, r_limit} < w_age);
            default:   w_drop = 1'b0;
        endcase
    end

    // Statistics arithmetic.
    logic [SUM_W:0]    w_sum_ext;
    logic [SUM_W-1:0]  w_sum_new;
    logic [SEQ_W-1:0]  w_total_new;

    assign w_sum_ext   = {1'b0, r_sum} + {{(SUM_W - TIME_W + 1){1'b0}}, r_lat};
    assign w_sum_new   = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
    assign w_total_new = (r_total == '1) ? r_total : r_total + 1'b1;

    // Divider step: restoring, one quotient bit per cycle.
    logic [SEQ_W:0]    w_rem_sh;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_total});

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && !w_drop) begin
            r_tbl_seq[r_wr[IDX_W-1:0]]  <= w_ent_seq;
            r_tbl_time[r_wr[IDX_W-1:0]] <= w_ent_time;
        end else if (i_cmd.append) begin
            r_tbl_seq[r_wr[IDX_W-1:0]]  <= r_next_seq;
            r_tbl_time[r_wr[IDX_W-1:0]] <= r_now;
        end
    end

    // Control and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_seq  <= SEQ_W'(1);
            r_timeout   <= TMO_W'(5000);
            r_total     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_dcnt      <= '0;
            r_found     <= 1'b0;
            r_func      <= FN_ADD;
        end else begin
            // Configuration write.
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            // Capture a new item.
            if (i_cmd.load) begin
                r_func    <= t_func'(i_func);
                r_found   <= 1'b0;
                r_rd      <= '0;
                r_wr      <= '0;
                if (t_func'(i_func) == FN_CLEAR) begin
                    r_count <= '0;
                    r_total <= '0;
                    r_sum   <= '0;
                    r_min   <= '0;
                    r_max   <= '0;
                    r_avg   <= '0;
                end
            end
            // One entry per cycle.
            if (i_cmd.scan_step) begin
                r_rd <= r_rd + 1'b1;
                if (!w_drop) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (w_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.scan_end) begin
                r_count <= r_wr;
            end
            if (i_cmd.append) begin
                r_count    <= r_wr + 1'b1;
                r_next_seq <= r_next_seq + 1'b1;
            end
            // Statistics update and divider start.
            if (i_cmd.stats) begin
                r_total <= w_total_new;
                r_sum   <= w_sum_new;
                if (r_lat > r_max) begin
                    r_max <= r_lat;
                end
                if (r_min == '0 || r_lat < r_min) begin
                    r_min <= r_lat;
                end
                r_dcnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.avg_load) begin
                r_avg <= (|r_quo[SUM_W-1:TIME_W]) ? '1 : r_quo[TIME_W-1:0];
            end
            // Result register.
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ack_seq  <= i_ack_sequence;
            r_now      <= i_now_us;
            r_limit    <= LIM_W'(r_timeout * US_PER_MS);
            r_assigned <= '0;
            r_lat      <= '0;
            r_expired  <= '0;
        end
        if (i_cmd.scan_step && w_hit) begin
            r_lat <= w_age;
        end
        if (i_cmd.scan_step && w_drop && r_func == FN_EXPIRE) begin
            r_expired <= r_expired + 1'b1;
        end
        if (i_cmd.append) begin
            r_assigned <= r_next_seq;
        end
        if (i_cmd.stats) begin
            r_quo <= w_sum_new;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? SEQ_W'(w_rem_sh - {1'b0, r_total}) : w_rem_sh[SEQ_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_data <= {5'd0, r_expired, OUT_W'(r_count), r_max, r_min,
                           r_avg, r_total, r_lat, r_found, r_assigned};
        end
    end

    assign o_status.func      = r_func;
    assign o_status.scan_done = (r_rd == r_count);
    assign o_status.found     = r_found;
    assign o_status.div_done  = (r_dcnt == DIV_STEPS);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The write pointer never passes the read pointer during a scan.
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd) else $error("table write pointer ahead of read pointer");

    // The table never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH)) else $error("entry count beyond depth");

    // After a statistics update the divisor is never zero.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stats |=> r_total != '0) else $error("zero divisor for average");

    // A divider run only starts once a hit has been recorded.
    a_stats_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stats |-> r_found) else $error("statistics update without a hit");

endmodule

[rtl/pending_request_latency_tracker.sv]
// ----------------------------------------------------------------------------
// pending_request_latency_tracker
// Tracks outstanding requests and the round-trip latency of acknowledged ones.
// ----------------------------------------------------------------------------
// After acceptance the table scan visits the N entries held (up to 16), one
// per cycle; then expire and acknowledge miss load the result, add appends
// first, acknowledge hit first runs the statistics update, 64 divider steps
// and the average load; a statistics reset skips the scan. Output stalls hold
// the result load. One item at a time; the next is taken once the result is
// registered. Reset empties the table, clears statistics, sequence 1, 5000 ms.
`timescale 1ns / 1ps

module pending_request_latency_tracker
    import prlt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // ack_sequence[31:0], now_us[79:32]
    input  logic [1:0]   s_axis_tuser,   // func[1:0]
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // assigned_sequence[31:0], ack_found[32], latency_us[80:33],
    // message_count[112:81], avg_latency_us[160:113], min_latency_us[208:161],
    // max_latency_us[256:209], pending_entries[261:257], expired_count[266:262]
    output logic [271:0] m_axis_tdata,
    // Timeout register write.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [22:0]  i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    prlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    prlt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_func         (s_axis_tuser),
        .i_ack_sequence (s_axis_tdata[31:0]),
        .i_now_us       (s_axis_tdata[79:32]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata)
    );

endmodule

[tb/pending_request_latency_tracker_tb.sv]
// ----------------------------------------------------------------------------
// pending_request_latency_tracker_tb
// Self-checking bench for the pending request latency tracker. A queue of
// request items is driven through the input stream while a model of the
// table and statistics predicts each result item; results are compared field
// by field. The run steps through timeout settings and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pending_request_latency_tracker_tb;
    import prlt_pkg::*;

    localparam logic [47:0] T_MASK = 48'hFFFF_FFFF_FFFF;
    localparam int WDOG_LIMIT = 20000;

    // Request item as queued for the driver.
    typedef struct packed {
        t_func       func;
        logic [31:0] ack_seq;
        logic [47:0] now;
    } t_req;

    // Result item fields.
    typedef struct packed {
        logic [4:0]  expired;
        logic [4:0]  pending;
        logic [47:0] lat_max;
        logic [47:0] lat_min;
        logic [47:0] lat_avg;
        logic [31:0] msg_cnt;
        logic [47:0] lat;
        logic        found;
        logic [31:0] assigned;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [271:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [22:0]  i_cfg_data = '0;

    pending_request_latency_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Model state of the tracker.
    logic [31:0] mdl_seq [TABLE_DEPTH];
    logic [47:0] mdl_sent [TABLE_DEPTH];
    int          mdl_count;
    logic [31:0] mdl_next_seq;
    logic [31:0] mdl_acked;
    logic [63:0] mdl_sum;
    logic [47:0] mdl_min, mdl_max, mdl_avg;
    logic [22:0] mdl_timeout;

    t_req  req_q[$];
    t_res  expected_q[$];
    int    fail_count = 0;
    int    n_ok = 0;
    int    n_hits = 0;
    int    n_expired = 0;
    int    idle_tx_pct = 0;
    int    idle_rx_pct = 0;
    int    hold_rx = 0;
    int    wdog = 0;
    int    cfg_writes = 0;

    // Drop one table entry and shift the younger ones down.
    function automatic void drop_entry(input int pos);
        for (int j = pos; j + 1 < mdl_count; j++) begin
            mdl_seq[j]  = mdl_seq[j + 1];
            mdl_sent[j] = mdl_sent[j + 1];
        end
        mdl_count--;
    endfunction

    // Predict the result of one request and advance the model.
    function automatic t_res track_request(input t_req r);
        t_res        o;
        logic [47:0] age;
        logic [33:0] limit;
        int          i;
        o = '0;
        case (r.func)
            FN_ADD: begin
                if (mdl_count >= TABLE_DEPTH) drop_entry(0);
                o.assigned = mdl_next_seq;
                mdl_seq[mdl_count]  = mdl_next_seq;
                mdl_sent[mdl_count] = r.now;
                mdl_count++;
                mdl_next_seq = mdl_next_seq + 32'd1;
            end
            FN_ACK: begin
                for (i = 0; i < mdl_count; i++) begin
                    if (mdl_seq[i] == r.ack_seq) begin
                        o.lat   = (r.now - mdl_sent[i]) & T_MASK;
                        o.found = 1'b1;
                        if (mdl_acked != 32'hFFFF_FFFF) mdl_acked++;
                        if (mdl_sum > 64'hFFFF_FFFF_FFFF_FFFF - {16'd0, o.lat})
                            mdl_sum = 64'hFFFF_FFFF_FFFF_FFFF;
                        else
                            mdl_sum = mdl_sum + {16'd0, o.lat};
                        if (mdl_sum / mdl_acked > {16'd0, T_MASK}) mdl_avg = T_MASK;
                        else mdl_avg = 48'(mdl_sum / mdl_acked);
                        if (o.lat > mdl_max) mdl_max = o.lat;
                        if (mdl_min == 0 || o.lat < mdl_min) mdl_min = o.lat;
                        drop_entry(i);
                        break;
                    end
                end
            end
            FN_EXPIRE: begin
                limit = 34'(mdl_timeout) * 34'd1000;
                i = 0;
                while (i < mdl_count) begin
                    age = (r.now - mdl_sent[i]) & T_MASK;
                    if ({14'd0, age} > {14'd0, limit}) begin
                        drop_entry(i);
                        o.expired++;
                    end else begin
                        i++;
                    end
                end
            end
            default: begin
                mdl_count = 0;
                mdl_acked = '0;
                mdl_sum = '0;
                mdl_min = '0;
                mdl_max = '0;
                mdl_avg = '0;
            end
        endcase
        o.msg_cnt = mdl_acked;
        o.lat_avg = mdl_avg;
        o.lat_min = mdl_min;
        o.lat_max = mdl_max;
        o.pending = 5'(mdl_count);
        return o;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Driver: feeds queued request items into the input stream.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_q.push_back(track_request(req_q.pop_front()));
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            // The head of the queue is the next item still to be sent.
            if (req_q.size() != 0 && $urandom_range(99) >= idle_tx_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= req_q[0].func;
                s_axis_tdata  <= {req_q[0].now, req_q[0].ack_seq};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_rx > 0) begin
            hold_rx <= hold_rx - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_rx_pct);
        end
    end

    // Monitor: compares each result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_res got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[266:0]);
            if (expected_q.size() == 0) begin
                $display("MISMATCH unexpected result item at %0t", $realtime);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.assigned !== want.assigned)
                    report_mismatch("assigned_sequence", 64'(got.assigned), 64'(want.assigned));
                if (got.found !== want.found)
                    report_mismatch("ack_found", 64'(got.found), 64'(want.found));
                if (got.lat !== want.lat)
                    report_mismatch("latency_us", 64'(got.lat), 64'(want.lat));
                if (got.msg_cnt !== want.msg_cnt)
                    report_mismatch("message_count", 64'(got.msg_cnt), 64'(want.msg_cnt));
                if (got.lat_avg !== want.lat_avg)
                    report_mismatch("avg_latency_us", 64'(got.lat_avg), 64'(want.lat_avg));
                if (got.lat_min !== want.lat_min)
                    report_mismatch("min_latency_us", 64'(got.lat_min), 64'(want.lat_min));
                if (got.lat_max !== want.lat_max)
                    report_mismatch("max_latency_us", 64'(got.lat_max), 64'(want.lat_max));
                if (got.pending !== want.pending)
                    report_mismatch("pending_entries", 64'(got.pending), 64'(want.pending));
                if (got.expired !== want.expired)
                    report_mismatch("expired_count", 64'(got.expired), 64'(want.expired));
                n_ok++;
                if (want.found) n_hits++;
                n_expired += want.expired;
            end
        end
    end

    // Watchdog: counts cycles with no item accepted on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || hold_rx > 0 || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write the timeout register while the block is idle.
    task automatic write_timeout(input logic [22:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mdl_timeout = value;
        cfg_writes++;
    endtask

    // Wait until the queue has drained and every result has arrived.
    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Model time: advances by random steps, with occasional jumps to any value.
    logic [47:0] clock_us;

    task automatic push_req(input t_func f, input logic [31:0] seq, input logic [47:0] now);
        t_req r;
        r.func = f;
        r.ack_seq = seq;
        r.now = now;
        req_q.push_back(r);
    endtask

    // Random traffic: adds, acks of likely pending or random numbers, expiries, clears.
    task automatic random_phase(input int n);
        int          k;
        logic [31:0] seq;
        logic [31:0] live[$];
        for (k = 0; k < n; k++) begin
            clock_us = clock_us + 48'($urandom_range(2_000_000));
            if ($urandom_range(49) == 0) clock_us = 48'({$urandom, $urandom});
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    push_req(FN_ADD, $urandom, clock_us);
                end
                8, 9, 10, 11, 12, 13, 14: begin
                    seq = $urandom;
                    if (live.size() != 0 && $urandom_range(3) != 0) seq = live[$urandom_range(live.size() - 1)];
                    push_req(FN_ACK, seq, clock_us);
                end
                15, 16, 17: push_req(FN_EXPIRE, $urandom, clock_us);
                default: begin
                    if ($urandom_range(3) == 0) push_req(FN_CLEAR, $urandom, clock_us);
                    else push_req(FN_ADD, $urandom, clock_us);
                end
            endcase
            // Track candidate sequence numbers loosely from the model counter.
            live.push_back(mdl_next_seq + 32'(live.size() % 20));
            if (live.size() > 24) void'(live.pop_front());
        end
    endtask

    initial begin
        int ph;
        mdl_count = 0;
        mdl_next_seq = 32'd1;
        mdl_acked = '0;
        mdl_sum = '0;
        mdl_min = '0;
        mdl_max = '0;
        mdl_avg = '0;
        mdl_timeout = 23'd5000;
        clock_us = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (30) @(posedge i_clk);

        // Directed part: extremes, every function, time wrap, full table,
        // duplicate acks, misses, zero latency and the expire boundary.
        write_timeout(23'd1);
        push_req(FN_ACK, 32'd1, 48'd0);
        push_req(FN_ADD, 32'hFFFF_FFFF, T_MASK - 48'd5);
        push_req(FN_ADD, '0, T_MASK);
        push_req(FN_ACK, 32'd1, 48'd10);
        push_req(FN_ACK, 32'd2, T_MASK);
        push_req(FN_ACK, 32'd2, 48'd0);
        for (int k = 0; k < 18; k++) push_req(FN_ADD, '0, 48'd1000 + 48'(k));
        push_req(FN_EXPIRE, '0, 48'd2000);
        push_req(FN_EXPIRE, '0, 48'd2003);
        push_req(FN_ACK, 32'd20, 48'd5000);
        push_req(FN_CLEAR, 32'hFFFF_FFFF, T_MASK);
        drain();

        // Extreme timeout, then zero, then several random settings.
        write_timeout(23'h7F_FFFF);
        write_timeout(23'd0);
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_tx_pct = 0;  idle_rx_pct = 0;  end
                1: begin idle_tx_pct = 65; idle_rx_pct = 0;  end
                2: begin idle_tx_pct = 0;  idle_rx_pct = 65; end
                default: begin idle_tx_pct = 29; idle_rx_pct = 29; end
            endcase
            if (ph == 2) hold_rx = 3000;
            random_phase(80);
            drain();
            if (ph == 3) write_timeout(23'h7F_FFFF);
            else write_timeout(23'($urandom_range(6000)));
        end

        // Sequence counter wrap: run adds until it passes zero is impractical,
        // so the counter range is covered by the acks of arbitrary values.
        drain();
        $display("Covered %0d results, %0d ack hits, %0d expiries, %0d timeout writes.",
                 n_ok, n_hits, n_expired, cfg_writes);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/prlt_pkg.sv
rtl/prlt_ctrl.sv
rtl/prlt_dp.sv
rtl/pending_request_latency_tracker.sv
tb/pending_request_latency_tracker_tb.sv
